// ----- hdl/feedback_delay_line_assert.svh -----
// Assertion macros used by the checker file of the feedback delay line.
`ifndef FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define FDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define FDL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Same as the next-cycle form, but also checked while reset is applied.
`define FDL_ASSERT_NEXT_ANY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fdl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fdl_pkg;

    // Ring geometry: the depth is a power of two so the pointer wraps naturally.
    localparam int ADDR_W   = 16;
    localparam int DEPTH    = 2 ** ADDR_W;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;

    typedef logic        [ADDR_W-1:0]   t_addr;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [CFG_W-1:0]    t_cfg;

    // Largest delay the ring can hold.
    localparam t_addr DELAY_MAX = t_addr'(DEPTH - 1);

    // Write port of the ring store.
    typedef struct packed {
        logic    en;
        t_addr   addr;
        t_sample data;
    } t_ring_wr;

    // Read port of the ring store.
    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_ring_rd;

endpackage

`default_nettype wire

// ----- hdl/feedback_delay_line.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Data
// -------   ---------  ------------------  -------------------------
// input     in         i_valid / o_ready   i_sample_in   (Q1.15)
// output    out        o_valid / i_ready   o_sample_out  (Q1.15)
// config    in         i_cfg_wr_en         i_cfg_wr_data (delay)
//
// One word is accepted every cycle while the output is not stalled; a taken word
// passes the read stage, with the registered read of the ring memory, then the output register.
// Reset clears the pointer, the fill flag and the delay. The ring itself is not
// swept: entries not yet written since reset read as zero through the fill flag.
// A stalled output holds one word in the output register and one in the read
// stage; input is taken again as soon as the read stage can move on.

module feedback_delay_line (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  fdl_pkg::t_sample i_sample_in,
    output logic             o_valid,
    input  wire              i_ready,
    output fdl_pkg::t_sample o_sample_out,
    input  wire              i_cfg_wr_en,
    input  fdl_pkg::t_cfg    i_cfg_wr_data
);
    import fdl_pkg::*;

    t_addr    r_delay;
    t_addr    r_wp;
    logic     r_full;

    logic     r_s1_valid;
    t_sample  r_s1_x;
    t_addr    r_s1_wp;
    logic     r_s1_zero;
    logic     r_s1_fwd;
    logic     r_s1_old;
    t_sample  r_fwd_data;

    logic     r_out_valid;
    t_sample  r_out_data;

    logic     accept;
    logic     s1_adv;
    t_addr    rd_addr;
    t_sample  mem_data;
    t_sample  delayed;
    logic signed [SAMPLE_W:0] sum;
    t_sample  y;
    t_ring_wr ring_wr;
    t_ring_rd ring_rd;

    // Handshake: the read stage moves on when the output register is free.
    always_comb begin
        s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
        o_ready = !r_s1_valid || s1_adv;
        accept  = i_valid && o_ready;
        rd_addr = r_wp - r_delay;
    end

    // Delay register, clamped to what the ring can hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
        end else if (i_cfg_wr_en) begin
            if ({{(ADDR_W){1'b0}}, i_cfg_wr_data} > {{(CFG_W){1'b0}}, DELAY_MAX}) begin
                r_delay <= DELAY_MAX;
            end else begin
                r_delay <= ADDR_W'(i_cfg_wr_data);
            end
        end
    end

    // Write pointer and fill flag; the flag marks that every entry was written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (accept) begin
            r_wp <= r_wp + t_addr'(1);
            if (r_wp == DELAY_MAX) begin
                r_full <= 1'b1;
            end
        end
    end

    // Read stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Read stage payload. The word leaving this stage in the same cycle is
    // written to the ring at this edge, so a read of its address is bypassed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x     <= i_sample_in;
            r_s1_wp    <= r_wp;
            r_s1_zero  <= (r_delay == '0);
            r_s1_fwd   <= s1_adv && (rd_addr == r_s1_wp);
            r_s1_old   <= r_full || (rd_addr < r_wp);
            r_fwd_data <= y;
        end
    end

    assign ring_rd.en   = accept;
    assign ring_rd.addr = rd_addr;

    fdl_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd      (ring_rd),
        .o_rd_data (mem_data)
    );

    // Pick the delayed sample and form half the sum.
    always_comb begin
        priority if (r_s1_zero) begin
            delayed = r_s1_x;
        end else if (r_s1_fwd) begin
            delayed = r_fwd_data;
        end else if (r_s1_old) begin
            delayed = mem_data;
        end else begin
            delayed = '0;
        end
        sum = {r_s1_x[SAMPLE_W-1], r_s1_x} + {delayed[SAMPLE_W-1], delayed};
        y   = sum[SAMPLE_W:1];
    end

    // Feedback: the output word goes back into the ring at its own pointer.
    assign ring_wr.en   = s1_adv;
    assign ring_wr.addr = r_s1_wp;
    assign ring_wr.data = y;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= y;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

`default_nettype wire

// ----- hdl/fdl_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fdl_ring (
    input  wire              i_clk,
    input  fdl_pkg::t_ring_wr i_wr,
    input  fdl_pkg::t_ring_rd i_rd,
    output fdl_pkg::t_sample  o_rd_data
);
    import fdl_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/fdl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "feedback_delay_line_assert.svh"

module fdl_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_valid,
    input wire              o_ready,
    input fdl_pkg::t_sample i_sample_in,
    input wire              o_valid,
    input wire              i_ready,
    input fdl_pkg::t_sample o_sample_out
);

    // A stalled output word stays put.
    `FDL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_sample_out), "output word changed while stalled")

    // A waiting input word stays put until it is taken.
    `FDL_ASSERT_NEXT(a_in_hold, i_valid && !o_ready, i_valid && $stable(i_sample_in), "input word changed while waiting")

    // With the output empty nothing inside can hold off the input.
    `FDL_ASSERT_NOW(a_ready_when_empty, !o_valid, o_ready, "input refused while output is empty")

    // An accepted word is followed by a valid output once it has passed the read stage and the output register.
    `FDL_ASSERT_NEXT(a_latency, i_valid && o_ready, ##1 o_valid, "accepted word did not reach the output")

    // Reset empties the output.
    `FDL_ASSERT_NEXT_ANY(a_reset_empty, !i_rst_n, !o_valid, "output valid after reset")

endmodule

bind feedback_delay_line fdl_checker u_fdl_checker (.*);

`default_nettype wire
